[rtl/core/suid_pkg.sv]
// ----------------------------------------------------------------------------
// suid_pkg
// Shared types and codes for the set union / intersection / difference block.
// ----------------------------------------------------------------------------
package suid_pkg;

   localparam int ELEM_W = 32;
   localparam int ACT_W  = 3;

   // action codes of the request item
   localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD_A    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_LOAD_B    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_UNION     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_INTERSECT = 3'd4;
   localparam logic [ACT_W-1:0] ACT_DIFF      = 3'd5;

   // controls of one list cell
   typedef struct packed {
      logic wr;    // take the load element
      logic rot;   // take the neighbor's value
   } list_ctl_type;

   // controls of one result store cell
   typedef struct packed {
      logic clear; // drop the valid bit
      logic shift; // take the neighbor's value and valid
   } emit_ctl_type;

endpackage

[rtl/core/set_union_intersect_difference_top.sv]
// ----------------------------------------------------------------------------
// set_union_intersect_difference_top
// Two element lists in rows of cells, with a scan that emits the union,
// intersection or difference of the lists one element per result item.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one item per action. Clear and loads give no result. A
//   load into a full list is dropped and sets the overflow flag, which
//   every result of later computes reports until clear. A compute (union,
//   intersection, difference) rotates list A through its cells once,
//   comparing the head against all cells of B and of the result store in
//   parallel; union then rotates list B the same way. A flush state then
//   sends the last result. req_stall is high for the whole compute; one
//   item is worked at a time.
//   rsp_ channel: results in list order, rsp_is_last on the final one. An
//   empty result is a single item with rsp_is_empty and rsp_is_last set.
//   One result is held back to learn whether it is the last; while rsp_stall
//   holds the output register full, the scan waits at the next emit.
//   Reset (synchronous) empties both lists, clears the flag and the output.
// ----------------------------------------------------------------------------
module set_union_intersect_difference_top
   import suid_pkg::*;
#(
   parameter int LIST_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [ELEM_W-1:0] req_element,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ELEM_W-1:0] rsp_result_value,
   output logic              rsp_is_last,
   output logic              rsp_is_empty,
   output logic              rsp_overflowed
);

   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int STEP_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int EMIT_DEPTH = 2 * LIST_DEPTH;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN_A = 4'b0010,
      ST_SCAN_B = 4'b0100,
      ST_FLUSH  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [ACT_W-1:0]  op_ff, op_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  count_a_ff, count_a_in;
   logic [CNT_W-1:0]  count_b_ff, count_b_in;
   logic              ovf_ff, ovf_in;
   logic              pend_v_ff, pend_v_in;
   logic [ELEM_W-1:0] pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic [ELEM_W-1:0] a_q [LIST_DEPTH];
   logic [ELEM_W-1:0] b_q [LIST_DEPTH];
   logic [ELEM_W-1:0] e_q [EMIT_DEPTH];
   logic              e_v [EMIT_DEPTH];
   logic [LIST_DEPTH-1:0] a_match, b_match;
   logic [EMIT_DEPTH-1:0] e_match;

   logic              req_fire, is_compute, load_a, load_b;
   logic              scanning, scan_a, scan_b, last_step;
   logic [ELEM_W-1:0] key;
   logic [CNT_W-1:0]  scan_count;
   logic              scan_active, in_b, in_emit, emit;
   logic              out_free, scan_go, emit_fire, flush_go;
   emit_ctl_type      e_ctl;

   // request decode
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign is_compute = req_action inside {ACT_UNION, ACT_INTERSECT, ACT_DIFF};
   assign load_a     = req_fire && (req_action == ACT_LOAD_A)
                       && (count_a_ff < CNT_W'(LIST_DEPTH));
   assign load_b     = req_fire && (req_action == ACT_LOAD_B)
                       && (count_b_ff < CNT_W'(LIST_DEPTH));

   // scan step: head of the rotating list against the broadcast compares
   assign scan_a      = (state_ff == ST_SCAN_A);
   assign scan_b      = (state_ff == ST_SCAN_B);
   assign scanning    = scan_a || scan_b;
   assign last_step   = (step_ff == STEP_W'(LIST_DEPTH - 1));
   assign key         = scan_b ? b_q[0] : a_q[0];
   assign scan_count  = scan_b ? count_b_ff : count_a_ff;
   assign scan_active = scanning && (CNT_W'(step_ff) < scan_count);
   assign in_b        = |b_match;
   assign in_emit     = |e_match;

   always_comb begin
      emit = 1'b0;
      if (scan_b) begin
         emit = scan_active && !in_emit;
      end else begin
         case (op_ff)
            ACT_UNION:     emit = scan_active;
            ACT_INTERSECT: emit = scan_active && in_b && !in_emit;
            ACT_DIFF:      emit = scan_active && !in_b;
            default:       emit = 1'b0;
         endcase
      end
   end

   // the scan waits only when a held result has nowhere to go
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_go   = scanning && !(emit && pend_v_ff && !out_free);
   assign emit_fire = emit && scan_go;
   assign flush_go  = (state_ff == ST_FLUSH) && out_free;

   // sequencer and list state
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      step_in    = step_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      ovf_in     = ovf_ff;
      pend_v_in  = pend_v_ff;
      pend_in    = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  ACT_CLEAR: begin
                     count_a_in = '0;
                     count_b_in = '0;
                     ovf_in     = 1'b0;
                  end
                  ACT_LOAD_A: begin
                     if (load_a) begin
                        count_a_in = count_a_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ACT_LOAD_B: begin
                     if (load_b) begin
                        count_b_in = count_b_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  default: begin
                     if (is_compute) begin
                        op_in     = req_action;
                        step_in   = '0;
                        pend_v_in = 1'b0;
                        state_in  = ST_SCAN_A;
                     end
                  end
               endcase
            end
         end
         ST_SCAN_A, ST_SCAN_B: begin
            if (scan_go) begin
               if (emit_fire) begin
                  pend_v_in = 1'b1;
                  pend_in   = key;
               end
               if (last_step) begin
                  step_in  = '0;
                  state_in = (scan_a && (op_ff == ACT_UNION)) ? ST_SCAN_B : ST_FLUSH;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (flush_go) begin
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_fire && pend_v_ff) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = pend_ff;
         rsp_last_in  = 1'b0;
         rsp_empty_in = 1'b0;
         rsp_ovf_in   = ovf_ff;
      end else if (flush_go) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = pend_v_ff ? pend_ff : '0;
         rsp_last_in  = 1'b1;
         rsp_empty_in = !pend_v_ff;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ovf_ff       <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ovf_ff       <= ovf_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pend_ff      <= pend_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // list rows: write at the fill index, rotate toward cell 0 during a scan
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_lists
      list_ctl_type a_ctl, b_ctl;

      assign a_ctl.wr  = load_a && (count_a_ff == CNT_W'(i));
      assign a_ctl.rot = scan_go && scan_a;
      assign b_ctl.wr  = load_b && (count_b_ff == CNT_W'(i));
      assign b_ctl.rot = scan_go && scan_b;

      suid_list_cell u_a_cell (
         .clock    (clock),
         .ctl      (a_ctl),
         .wr_data  (req_element),
         .rot_data (a_q[(i + 1) % LIST_DEPTH]),
         .in_use   (1'b0),
         .key      (key),
         .value    (a_q[i]),
         .match    (a_match[i])
      );

      suid_list_cell u_b_cell (
         .clock    (clock),
         .ctl      (b_ctl),
         .wr_data  (req_element),
         .rot_data (b_q[(i + 1) % LIST_DEPTH]),
         .in_use   (CNT_W'(i) < count_b_ff),
         .key      (key),
         .value    (b_q[i]),
         .match    (b_match[i])
      );
   end

   // result store: new element enters at cell 0, older ones move up
   assign e_ctl.clear = req_fire && is_compute;
   assign e_ctl.shift = emit_fire;

   for (genvar j = 0; j < EMIT_DEPTH; j++) begin : g_emit
      logic [ELEM_W-1:0] sh_data;
      logic              sh_valid;

      if (j == 0) begin : g_head
         assign sh_data  = key;
         assign sh_valid = 1'b1;
      end else begin : g_body
         assign sh_data  = e_q[j-1];
         assign sh_valid = e_v[j-1];
      end

      suid_emit_cell u_e_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (e_ctl),
         .shift_data  (sh_data),
         .shift_valid (sh_valid),
         .key         (key),
         .value       (e_q[j]),
         .valid       (e_v[j]),
         .match       (e_match[j])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_is_last      = rsp_last_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_count_a_range: assert property (@(posedge clock) disable iff (reset)
      count_a_ff <= CNT_W'(LIST_DEPTH))
      else $error("list A count beyond depth");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_is_last && (rsp_result_value == '0))
      else $error("empty result not a single last item");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_v_ff)
      else $error("held result left behind after a compute");

   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_compute |=> (state_ff == ST_SCAN_A))
      else $error("compute did not start the scan of list A");

   a_scan_b_union: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_B) |-> (op_ff == ACT_UNION))
      else $error("list B scanned outside a union");
`endif

endmodule

[rtl/core/suid_list_cell.sv]
// ----------------------------------------------------------------------------
// suid_list_cell
// One entry of list A or B: written on load, rotated during a scan, and
// compared against the broadcast key.
// ----------------------------------------------------------------------------
module suid_list_cell
   import suid_pkg::*;
(
   input  logic              clock,
   input  list_ctl_type      ctl,
   input  logic [ELEM_W-1:0] wr_data,
   input  logic [ELEM_W-1:0] rot_data,
   input  logic              in_use,
   input  logic [ELEM_W-1:0] key,
   output logic [ELEM_W-1:0] value,
   output logic              match
);

   logic [ELEM_W-1:0] value_ff;
   logic [ELEM_W-1:0] value_in;

   // load wins over rotate; the two never meet
   always_comb begin
      value_in = value_ff;
      if (ctl.wr) begin
         value_in = wr_data;
      end else if (ctl.rot) begin
         value_in = rot_data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = in_use && (value_ff == key);

endmodule

[rtl/core/suid_emit_cell.sv]
// ----------------------------------------------------------------------------
// suid_emit_cell
// One entry of the result store: a shift chain of emitted elements with a
// valid bit, compared against the broadcast key for duplicate checks.
// ----------------------------------------------------------------------------
module suid_emit_cell
   import suid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  emit_ctl_type      ctl,
   input  logic [ELEM_W-1:0] shift_data,
   input  logic              shift_valid,
   input  logic [ELEM_W-1:0] key,
   output logic [ELEM_W-1:0] value,
   output logic              valid,
   output logic              match
);

   logic [ELEM_W-1:0] value_ff;
   logic [ELEM_W-1:0] value_in;
   logic              valid_ff;
   logic              valid_in;

   // next value and valid
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         value_in = shift_data;
         valid_in = shift_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign match = valid_ff && (value_ff == key);

endmodule
